// ===== rtl/core/fba_pkg.sv =====
// Shared types and constants for the frame bitmap allocator.
package fba_pkg;

  // Default sizing of the bitmap
  localparam int unsigned FramesDef   = 4096;
  localparam int unsigned WordBitsDef = 32;

  // Fixed field widths
  localparam int unsigned ActionW    = 3;
  localparam int unsigned AddrW      = 24;
  localparam int unsigned PFrameW    = 12;
  localparam int unsigned LimitW     = 13;
  localparam int unsigned FrameShift = 12;  // 4 KiB frames

  localparam logic [LimitW-1:0] LimitReset = 13'd4096;

  typedef enum logic [ActionW-1:0] {
    ACT_SET   = 3'd0,
    ACT_CLEAR = 3'd1,
    ACT_TEST  = 3'd2,
    ACT_ALLOC = 3'd3,
    ACT_FREE  = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_MODIFY,
    ST_SCAN,
    ST_DONE
  } state_e;

  // One result item
  typedef struct packed {
    logic               present;
    logic               rw;
    logic               user;
    logic [PFrameW-1:0] new_frame;
    logic               changed;
    logic               was_set;
    logic               no_free;
  } result_t;

endpackage

// ===== rtl/core/frame_bitmap_allocator.sv =====
// Frame bitmap allocator: one bit per 4 KiB frame, held in a word-wide memory.
// Set, clear, test and free read one word, then modify and write it back (test only
// reads) before the result register; items that touch no word go straight to it.
// Allocate with page frame zero and a nonzero limit scans one word a cycle up to the
// limit; the input stalls until each result is loaded, so a stalled result holds the input.
// Reset sweeps the bitmap to zero one word at a time, input stalled; limit resets to 4096.
module frame_bitmap_allocator #(
  parameter int unsigned FRAMES    = fba_pkg::FramesDef,
  parameter int unsigned WORD_BITS = fba_pkg::WordBitsDef  // power of two
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [fba_pkg::LimitW-1:0]  cfg_frame_limit_i,
  // input items
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [fba_pkg::ActionW-1:0] action_i,
  input  logic [fba_pkg::AddrW-1:0]   frame_address_i,
  input  logic [fba_pkg::PFrameW-1:0] page_frame_i,
  input  logic                        is_kernel_space_i,
  input  logic                        is_writeable_i,
  // result items
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        page_present_o,
  output logic                        page_rw_o,
  output logic                        page_user_o,
  output logic [fba_pkg::PFrameW-1:0] new_page_frame_o,
  output logic                        page_changed_o,
  output logic                        bit_was_set_o,
  output logic                        no_free_frame_o
);

  localparam int unsigned WordCount = (FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned WidxW     = (WordCount > 1) ? $clog2(WordCount) : 1;
  localparam int unsigned BitW      = $clog2(WORD_BITS);
  localparam int unsigned FramesW   = $clog2(FRAMES + 1);
  localparam int unsigned LimW      = (FramesW > fba_pkg::LimitW) ? FramesW : fba_pkg::LimitW;
  localparam int unsigned BaseW     = LimW + 1;

  // state and registers
  fba_pkg::state_e              state_q, state_d;
  logic [fba_pkg::LimitW-1:0]   frame_limit_q;
  logic [WidxW-1:0]             clr_q, clr_d;
  fba_pkg::action_e             act_q, act_d;
  logic [fba_pkg::PFrameW-1:0]  frame_q, frame_d;
  logic                         kspace_q, kspace_d;
  logic                         wr_q, wr_d;
  logic [WidxW-1:0]             scan_word_q, scan_word_d;
  logic [WidxW-1:0]             data_word_q, data_word_d;
  logic [BaseW-1:0]             data_base_q, data_base_d;
  logic                         data_vld_q, data_vld_d;
  fba_pkg::result_t             res_q, res_d;
  fba_pkg::result_t             out_q, out_d;
  logic                         out_valid_q, out_valid_d;

  // memory port signals
  logic                         mem_we;
  logic [WidxW-1:0]             mem_waddr;
  logic [WORD_BITS-1:0]         mem_wdata;
  logic                         mem_re;
  logic [WidxW-1:0]             mem_raddr;
  logic [WORD_BITS-1:0]         mem_rdata;

  // decode of the offered item
  fba_pkg::action_e             act_in;
  logic [fba_pkg::PFrameW-1:0]  addr_frame;
  logic [fba_pkg::PFrameW-1:0]  sel_frame;
  logic                         in_rng;
  logic                         pf_zero;
  logic                         go_read;
  logic                         go_scan;
  logic                         in_xfer;
  logic [LimW-1:0]              lim;

  // single-frame addressing of the held item
  logic [31:0]                  frame_ext;
  logic [WidxW-1:0]             word_idx;
  logic [BitW-1:0]              bit_idx;
  logic [WORD_BITS-1:0]         bit_mask;

  // scan evaluation
  logic [BaseW-1:0]             rem;
  logic [WORD_BITS-1:0]         masked;
  logic                         found;
  logic [BitW-1:0]              found_idx;
  logic                         scan_last;
  logic                         out_load;

  fba_bitmap_ram #(
    .Depth (WordCount),
    .Width (WORD_BITS),
    .AddrW (WidxW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != fba_pkg::ST_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_load    = (state_q == fba_pkg::ST_DONE) && (!out_valid_q || !out_stall_i);

  // Clamp the frame limit to the bitmap size
  assign lim = (LimW'(frame_limit_q) > LimW'(FRAMES)) ? LimW'(FRAMES) : LimW'(frame_limit_q);

  // Decode the offered item
  always_comb begin
    act_in     = fba_pkg::action_e'(action_i);
    addr_frame = frame_address_i[fba_pkg::AddrW-1:fba_pkg::FrameShift];
    pf_zero    = (page_frame_i == '0);
    sel_frame  = (act_in == fba_pkg::ACT_FREE) ? page_frame_i : addr_frame;
    in_rng     = (32'(sel_frame) < 32'(FRAMES));
    go_read    = 1'b0;
    go_scan    = 1'b0;
    case (act_in)
      fba_pkg::ACT_SET, fba_pkg::ACT_CLEAR, fba_pkg::ACT_TEST: go_read = in_rng;
      fba_pkg::ACT_FREE:  go_read = in_rng && !pf_zero;
      fba_pkg::ACT_ALLOC: go_scan = pf_zero && (lim != '0);
      default: ;
    endcase
  end

  // Locate the held frame within the bitmap
  always_comb begin
    frame_ext = 32'(frame_q);
    word_idx  = WidxW'(frame_ext >> BitW);
    bit_idx   = BitW'(frame_ext);
    bit_mask  = WORD_BITS'(1) << bit_idx;
  end

  // Find the lowest free frame below the limit in the word on the read port
  always_comb begin
    rem       = BaseW'(lim) - data_base_q;
    masked    = mem_rdata;
    found     = 1'b0;
    found_idx = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (!(BaseW'(i) < rem)) begin
        masked[i] = 1'b1;
      end
    end
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!masked[i]) begin
        found     = 1'b1;
        found_idx = BitW'(i);
      end
    end
    scan_last = (data_base_q + BaseW'(WORD_BITS)) >= BaseW'(lim);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      fba_pkg::ST_CLEAR: begin
        if (clr_q == WidxW'(WordCount - 1)) state_d = fba_pkg::ST_IDLE;
      end
      fba_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (go_read)      state_d = fba_pkg::ST_READ;
          else if (go_scan) state_d = fba_pkg::ST_SCAN;
          else              state_d = fba_pkg::ST_DONE;
        end
      end
      fba_pkg::ST_READ:   state_d = fba_pkg::ST_MODIFY;
      fba_pkg::ST_MODIFY: state_d = fba_pkg::ST_DONE;
      fba_pkg::ST_SCAN: begin
        if (data_vld_q && (found || scan_last)) state_d = fba_pkg::ST_DONE;
      end
      fba_pkg::ST_DONE: begin
        if (out_load) state_d = fba_pkg::ST_IDLE;
      end
      default: state_d = fba_pkg::ST_IDLE;
    endcase
  end

  // Datapath and memory control per state
  always_comb begin
    clr_d       = clr_q;
    act_d       = act_q;
    frame_d     = frame_q;
    kspace_d    = kspace_q;
    wr_d        = wr_q;
    scan_word_d = scan_word_q;
    data_word_d = data_word_q;
    data_base_d = data_base_q;
    data_vld_d  = data_vld_q;
    res_d       = res_q;
    mem_we      = 1'b0;
    mem_waddr   = word_idx;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = word_idx;
    case (state_q)
      fba_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        clr_d     = clr_q + WidxW'(1);
      end
      fba_pkg::ST_IDLE: begin
        if (in_xfer) begin
          act_d       = act_in;
          frame_d     = sel_frame;
          kspace_d    = is_kernel_space_i;
          wr_d        = is_writeable_i;
          scan_word_d = '0;
          data_word_d = '0;
          data_base_d = '0;
          data_vld_d  = 1'b0;
          res_d           = '0;
          res_d.new_frame = page_frame_i;
          if (act_in == fba_pkg::ACT_FREE && !pf_zero) begin
            res_d.new_frame = '0;
            res_d.changed   = 1'b1;
          end
          if (act_in == fba_pkg::ACT_ALLOC && pf_zero && lim == '0) begin
            res_d.no_free = 1'b1;
          end
        end
      end
      fba_pkg::ST_READ: begin
        mem_re = 1'b1;
      end
      fba_pkg::ST_MODIFY: begin
        case (act_q)
          fba_pkg::ACT_SET: begin
            mem_we    = 1'b1;
            mem_wdata = mem_rdata | bit_mask;
          end
          fba_pkg::ACT_CLEAR, fba_pkg::ACT_FREE: begin
            mem_we    = 1'b1;
            mem_wdata = mem_rdata & ~bit_mask;
          end
          fba_pkg::ACT_TEST: res_d.was_set = mem_rdata[bit_idx];
          default: ;
        endcase
      end
      fba_pkg::ST_SCAN: begin
        // Keep one read in flight while checking the word that has arrived
        mem_re      = 1'b1;
        mem_raddr   = scan_word_q;
        scan_word_d = scan_word_q + WidxW'(1);
        data_word_d = scan_word_q;
        data_vld_d  = 1'b1;
        if (data_vld_q) begin
          data_base_d = data_base_q + BaseW'(WORD_BITS);
          if (found) begin
            mem_we          = 1'b1;
            mem_waddr       = data_word_q;
            mem_wdata       = mem_rdata | (WORD_BITS'(1) << found_idx);
            res_d.present   = 1'b1;
            res_d.rw        = wr_q;
            res_d.user      = kspace_q;
            res_d.new_frame = fba_pkg::PFrameW'(data_base_q + BaseW'(found_idx));
            res_d.changed   = 1'b1;
          end else if (scan_last) begin
            res_d.no_free = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // Output register
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (out_load) begin
      out_d       = res_q;
      out_valid_d = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= fba_pkg::ST_CLEAR;
      clr_q         <= '0;
      frame_limit_q <= fba_pkg::LimitReset;
      out_valid_q   <= 1'b0;
      data_vld_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      data_vld_q  <= data_vld_d;
      if (cfg_valid_i && cfg_ready_o) begin
        frame_limit_q <= cfg_frame_limit_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    act_q       <= act_d;
    frame_q     <= frame_d;
    kspace_q    <= kspace_d;
    wr_q        <= wr_d;
    scan_word_q <= scan_word_d;
    data_word_q <= data_word_d;
    data_base_q <= data_base_d;
    res_q       <= res_d;
    out_q       <= out_d;
  end

  assign out_valid_o      = out_valid_q;
  assign page_present_o   = out_q.present;
  assign page_rw_o        = out_q.rw;
  assign page_user_o      = out_q.user;
  assign new_page_frame_o = out_q.new_frame;
  assign page_changed_o   = out_q.changed;
  assign bit_was_set_o    = out_q.was_set;
  assign no_free_frame_o  = out_q.no_free;

endmodule

// ===== rtl/core/fba_bitmap_ram.sv =====
// Bitmap word store: one write port, one read port with registered read data.
module fba_bitmap_ram #(
  parameter int unsigned Depth = 128,
  parameter int unsigned Width = 32,
  parameter int unsigned AddrW = 7
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the frame bitmap allocator.
module tb;

  localparam int unsigned Frames       = fba_pkg::FramesDef;
  localparam int unsigned WordBits     = fba_pkg::WordBitsDef;
  localparam int unsigned WordCount    = Frames / WordBits;
  localparam int unsigned HalfPeriod   = 6;
  localparam int unsigned ResetCycles  = 12;
  localparam int unsigned SettleCycles = 200;
  localparam int unsigned TimeoutCycles = 1500000;
  localparam int unsigned PhaseItems   = 90;

  // One request as presented on the input channel
  typedef struct {
    logic [fba_pkg::ActionW-1:0] action;
    logic [fba_pkg::AddrW-1:0]   addr;
    logic [fba_pkg::PFrameW-1:0] pframe;
    logic                        kspace;
    logic                        wr;
  } frame_req_t;

  logic                          clk_i             = 1'b0;
  logic                          rst_ni            = 1'b0;
  logic                          cfg_valid_i       = 1'b0;
  logic                          cfg_ready_o;
  logic [fba_pkg::LimitW-1:0]    cfg_frame_limit_i = '0;
  logic                          in_valid_i        = 1'b0;
  logic                          in_stall_o;
  logic [fba_pkg::ActionW-1:0]   action_i          = '0;
  logic [fba_pkg::AddrW-1:0]     frame_address_i   = '0;
  logic [fba_pkg::PFrameW-1:0]   page_frame_i      = '0;
  logic                          is_kernel_space_i = 1'b0;
  logic                          is_writeable_i    = 1'b0;
  logic                          out_valid_o;
  logic                          out_stall_i       = 1'b0;
  logic                          page_present_o;
  logic                          page_rw_o;
  logic                          page_user_o;
  logic [fba_pkg::PFrameW-1:0]   new_page_frame_o;
  logic                          page_changed_o;
  logic                          bit_was_set_o;
  logic                          no_free_frame_o;

  // Shadow of the block's state and register
  logic [WordBits-1:0]           frame_words [WordCount];
  logic [fba_pkg::LimitW-1:0]    limit_shadow;

  frame_req_t                    pending_reqs [$];
  fba_pkg::result_t              expected_results [$];
  frame_req_t                    drv_req;
  bit                            take_next;
  fba_pkg::result_t              seen_res;
  fba_pkg::result_t              want_res;
  int                            send_gap_pct   = 0;
  int                            recv_stall_pct = 0;
  int                            err_count      = 0;
  int                            result_idx     = 0;

  frame_bitmap_allocator u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_frame_limit_i (cfg_frame_limit_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .action_i          (action_i),
    .frame_address_i   (frame_address_i),
    .page_frame_i      (page_frame_i),
    .is_kernel_space_i (is_kernel_space_i),
    .is_writeable_i    (is_writeable_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .page_present_o    (page_present_o),
    .page_rw_o         (page_rw_o),
    .page_user_o       (page_user_o),
    .new_page_frame_o  (new_page_frame_o),
    .page_changed_o    (page_changed_o),
    .bit_was_set_o     (bit_was_set_o),
    .no_free_frame_o   (no_free_frame_o)
  );

  always begin
    #HalfPeriod clk_i = 1'b1;
    #HalfPeriod clk_i = 1'b0;
  end

  // Apply one request to the shadow bitmap and return the entry it yields
  function automatic fba_pkg::result_t apply_frame_op(input frame_req_t req);
    fba_pkg::result_t             res;
    logic [fba_pkg::PFrameW-1:0]  fidx;
    int unsigned                  lim;
    int unsigned                  f;
    int unsigned                  hit;
    bit                           found;
    res           = '0;
    res.new_frame = req.pframe;
    fidx          = req.addr[fba_pkg::AddrW-1:fba_pkg::FrameShift];
    found         = 1'b0;
    hit           = 0;
    case (req.action)
      fba_pkg::ACT_SET:   frame_words[fidx / WordBits][fidx % WordBits] = 1'b1;
      fba_pkg::ACT_CLEAR: frame_words[fidx / WordBits][fidx % WordBits] = 1'b0;
      fba_pkg::ACT_TEST:  res.was_set = frame_words[fidx / WordBits][fidx % WordBits];
      fba_pkg::ACT_ALLOC: begin
        if (req.pframe == '0) begin
          lim = (limit_shadow > Frames) ? Frames : limit_shadow;
          for (f = 0; f < lim && !found; f++) begin
            if (!frame_words[f / WordBits][f % WordBits]) begin
              found = 1'b1;
              hit   = f;
            end
          end
          if (found) begin
            frame_words[hit / WordBits][hit % WordBits] = 1'b1;
            res.present   = 1'b1;
            res.rw        = req.wr;
            res.user      = req.kspace;
            res.new_frame = fba_pkg::PFrameW'(hit);
            res.changed   = 1'b1;
          end else begin
            res.no_free = 1'b1;
          end
        end
      end
      fba_pkg::ACT_FREE: begin
        if (req.pframe != '0) begin
          frame_words[req.pframe / WordBits][req.pframe % WordBits] = 1'b0;
          res.new_frame = '0;
          res.changed   = 1'b1;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Print one line per mismatch and count it
  task automatic report_mismatch(input string what, input int got_val, input int want_val);
    err_count++;
    $display("mismatch at result %0d: %s got %0d expected %0d",
             result_idx, what, got_val, want_val);
  endtask

  task automatic push_req(input logic [fba_pkg::ActionW-1:0] act,
                          input logic [fba_pkg::AddrW-1:0] addr,
                          input logic [fba_pkg::PFrameW-1:0] pframe, input logic kspace,
                          input logic wr);
    frame_req_t req;
    req.action = act;
    req.addr   = addr;
    req.pframe = pframe;
    req.kspace = kspace;
    req.wr     = wr;
    pending_reqs.push_back(req);
  endtask

  // Write the frame limit over its own channel; only called when no request is outstanding
  task automatic write_frame_limit(input logic [fba_pkg::LimitW-1:0] value);
    @(posedge clk_i);
    cfg_valid_i       <= 1'b1;
    cfg_frame_limit_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i       <= 1'b0;
    limit_shadow = value;
  endtask

  // Hold until every queued request has gone in and every result has come out
  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_reqs.size() != 0 || in_valid_i || expected_results.size() != 0);
  endtask

  // Fill a phase with mostly allocate/free traffic near the low frames, plus noise
  task automatic queue_random_reqs(input int count, input int unsigned eff_limit);
    int unsigned win;
    int unsigned pick;
    int unsigned fr;
    int unsigned spare_lo;
    int unsigned spare_hi;
    logic [fba_pkg::AddrW-1:0] addr;
    win      = (eff_limit == 0) ? 8 : ((eff_limit > 128) ? 132 : eff_limit + 4);
    spare_lo = int'(fba_pkg::ACT_FREE) + 1;
    spare_hi = (1 << fba_pkg::ActionW) - 1;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      fr   = $urandom_range(0, win);
      if ($urandom_range(3) == 0)
        addr = fba_pkg::AddrW'($urandom);
      else
        addr = {fba_pkg::PFrameW'(fr), 12'($urandom_range(0, 4095))};
      if (pick < 30)
        push_req(fba_pkg::ACT_ALLOC, fba_pkg::AddrW'($urandom), '0,
                 1'($urandom), 1'($urandom));
      else if (pick < 38)
        push_req(fba_pkg::ACT_ALLOC, fba_pkg::AddrW'($urandom),
                 fba_pkg::PFrameW'($urandom_range(1, 4095)), 1'($urandom), 1'($urandom));
      else if (pick < 58)
        push_req(fba_pkg::ACT_FREE, fba_pkg::AddrW'($urandom), fba_pkg::PFrameW'(fr),
                 1'($urandom), 1'($urandom));
      else if (pick < 70)
        push_req(fba_pkg::ACT_SET, addr, fba_pkg::PFrameW'($urandom),
                 1'($urandom), 1'($urandom));
      else if (pick < 80)
        push_req(fba_pkg::ACT_CLEAR, addr, fba_pkg::PFrameW'($urandom),
                 1'($urandom), 1'($urandom));
      else if (pick < 92)
        push_req(fba_pkg::ACT_TEST, addr, fba_pkg::PFrameW'($urandom),
                 1'($urandom), 1'($urandom));
      else if (pick < 96)
        push_req(fba_pkg::ActionW'($urandom_range(spare_hi, spare_lo)),
                 fba_pkg::AddrW'($urandom), fba_pkg::PFrameW'($urandom),
                 1'($urandom), 1'($urandom));
      else
        push_req(fba_pkg::ActionW'($urandom), fba_pkg::AddrW'($urandom),
                 fba_pkg::PFrameW'($urandom), 1'($urandom), 1'($urandom));
    end
  endtask

  // Driver: hold the payload while stalled, advance on each transfer
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      take_next = !in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        expected_results.push_back(apply_frame_op(drv_req));
        take_next = 1'b1;
      end
      if (take_next) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          drv_req = pending_reqs.pop_front();
          in_valid_i        <= 1'b1;
          action_i          <= drv_req.action;
          frame_address_i   <= drv_req.addr;
          page_frame_i      <= drv_req.pframe;
          is_kernel_space_i <= drv_req.kspace;
          is_writeable_i    <= drv_req.wr;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transfer against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen_res = {page_present_o, page_rw_o, page_user_o, new_page_frame_o,
                  page_changed_o, bit_was_set_o, no_free_frame_o};
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, outstanding", 1, 0);
      end else begin
        want_res = expected_results.pop_front();
        if (seen_res.present !== want_res.present)
          report_mismatch("page_present", int'(seen_res.present), int'(want_res.present));
        if (seen_res.rw !== want_res.rw)
          report_mismatch("page_rw", int'(seen_res.rw), int'(want_res.rw));
        if (seen_res.user !== want_res.user)
          report_mismatch("page_user", int'(seen_res.user), int'(want_res.user));
        if (seen_res.new_frame !== want_res.new_frame)
          report_mismatch("new_page_frame", int'(seen_res.new_frame),
                          int'(want_res.new_frame));
        if (seen_res.changed !== want_res.changed)
          report_mismatch("page_changed", int'(seen_res.changed), int'(want_res.changed));
        if (seen_res.was_set !== want_res.was_set)
          report_mismatch("bit_was_set", int'(seen_res.was_set), int'(want_res.was_set));
        if (seen_res.no_free !== want_res.no_free)
          report_mismatch("no_free_frame", int'(seen_res.no_free), int'(want_res.no_free));
      end
      result_idx++;
    end
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Stimulus sequence: directed checks, then random phases over several limits
  initial begin
    logic [fba_pkg::LimitW-1:0] rand_limits [9];
    int unsigned eff;
    rand_limits = '{13'd8191, 13'd40, 13'd1, 13'd4097, 13'd64, 13'd4096,
                    13'd2, 13'd33, 13'd300};
    for (int w = 0; w < WordCount; w++) frame_words[w] = '0;
    limit_shadow = fba_pkg::LimitReset;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_gap_pct   = 16;
    recv_stall_pct = 73;

    // Full range: top and bottom frames, frame zero, held page, empty free
    write_frame_limit(13'd4096);
    push_req(fba_pkg::ACT_TEST,  24'h000000, 12'h000, 1'b0, 1'b0);
    push_req(fba_pkg::ACT_SET,   24'hFFFFFF, 12'hFFF, 1'b1, 1'b1);
    push_req(fba_pkg::ACT_TEST,  24'hFFFFFF, 12'h000, 1'b0, 1'b0);
    push_req(fba_pkg::ACT_ALLOC, 24'h000000, 12'h000, 1'b1, 1'b1);
    push_req(fba_pkg::ACT_ALLOC, 24'hFFFFFF, 12'h000, 1'b0, 1'b0);
    push_req(fba_pkg::ACT_ALLOC, 24'h000000, 12'h005, 1'b1, 1'b1);
    push_req(fba_pkg::ACT_FREE,  24'hFFFFFF, 12'h000, 1'b1, 1'b1);
    push_req(fba_pkg::ACT_FREE,  24'h000000, 12'h001, 1'b0, 1'b0);
    push_req(fba_pkg::ACT_TEST,  24'h001FFF, 12'h000, 1'b0, 1'b0);
    push_req(fba_pkg::ACT_ALLOC, 24'h000000, 12'h000, 1'b1, 1'b0);
    push_req(fba_pkg::ACT_CLEAR, 24'hFFF000, 12'h000, 1'b0, 1'b0);
    push_req(fba_pkg::ACT_TEST,  24'hFFF123, 12'h000, 1'b0, 1'b0);
    push_req(fba_pkg::ACT_SET,   24'h002ABC, 12'h000, 1'b0, 1'b0);
    push_req(fba_pkg::ACT_ALLOC, 24'h000000, 12'h000, 1'b0, 1'b1);
    // Every code above the last defined action
    for (int a = int'(fba_pkg::ACT_FREE) + 1; a < (1 << fba_pkg::ActionW); a++)
      push_req(fba_pkg::ActionW'(a), 24'hFFFFFF, 12'hFFF, 1'b1, 1'b1);
    push_req(fba_pkg::ACT_FREE,  24'h000000, 12'hFFF, 1'b0, 1'b0);
    wait_drained();

    // Zero limit: allocate always runs dry
    write_frame_limit(13'd0);
    push_req(fba_pkg::ACT_ALLOC, 24'h000000, 12'h000, 1'b1, 1'b1);
    push_req(fba_pkg::ACT_ALLOC, 24'hFFFFFF, 12'h000, 1'b0, 1'b0);
    push_req(fba_pkg::ACT_TEST,  24'h000000, 12'h000, 1'b0, 1'b0);
    wait_drained();

    // Tight limit: run dry, free one frame, take it back, run dry again
    write_frame_limit(13'd3);
    push_req(fba_pkg::ACT_ALLOC, 24'h000000, 12'h000, 1'b1, 1'b1);
    push_req(fba_pkg::ACT_CLEAR, 24'h001000, 12'h000, 1'b0, 1'b0);
    push_req(fba_pkg::ACT_ALLOC, 24'h000000, 12'h000, 1'b0, 1'b1);
    push_req(fba_pkg::ACT_ALLOC, 24'h000000, 12'h000, 1'b1, 1'b0);
    wait_drained();

    // Random phases under three idling regimes
    for (int p = 0; p < 9; p++) begin
      if (p < 3) begin
        send_gap_pct   = 16;
        recv_stall_pct = 73;
      end else if (p < 6) begin
        send_gap_pct   = 73;
        recv_stall_pct = 16;
      end else begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end
      write_frame_limit(rand_limits[p]);
      eff = (rand_limits[p] > Frames) ? Frames : rand_limits[p];
      queue_random_reqs(PhaseItems, eff);
      wait_drained();
    end

    // Let any stray result show up before the verdict
    repeat (SettleCycles) @(posedge clk_i);
    if (expected_results.size() != 0)
      report_mismatch("results still outstanding", 0, expected_results.size());
    if (err_count == 0) begin
      $display("frame_bitmap_allocator regression: pass");
    end else begin
      $display("frame_bitmap_allocator regression: fail");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #(TimeoutCycles * 2 * HalfPeriod);
    $display("frame_bitmap_allocator regression: fail");
    $finish;
  end

endmodule
